FILE: src/so3amc_pkg.sv
// shared types, codes and microcode for the so3 attitude moment controller
// no dependencies; imported by so3_attitude_moment_controller
package so3amc_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int PC_W           = 7;

    localparam logic [33:0] Q30_TWO_PI  = 34'd6746518852;
    localparam logic [33:0] Q30_PI      = 34'd3373259426;
    localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

    localparam logic [2:0] CMD_SET_RD = 3'd0;
    localparam logic [2:0] CMD_SET_RM = 3'd1;
    localparam logic [2:0] CMD_SET_WD = 3'd2;
    localparam logic [2:0] CMD_SET_WM = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [2:0] CFG_KR_XY = 3'd0;
    localparam logic [2:0] CFG_KR_Z  = 3'd1;
    localparam logic [2:0] CFG_KW_XY = 3'd2;
    localparam logic [2:0] CFG_KW_Z  = 3'd3;
    localparam logic [2:0] CFG_I_XY  = 3'd4;
    localparam logic [2:0] CFG_I_Z   = 3'd5;
    localparam int         CFG_NUM   = 6;

    localparam logic [2:0] RES_NONE = 3'd0;
    localparam logic [2:0] RES_MX   = 3'd1;
    localparam logic [2:0] RES_MY   = 3'd2;
    localparam logic [2:0] RES_MZ   = 3'd3;
    localparam logic [2:0] RES_EX   = 3'd4;
    localparam logic [2:0] RES_EY   = 3'd5;
    localparam logic [2:0] RES_EZ   = 3'd6;

    // memory map
    localparam logic [6:0] A_RD  = 7'd0;
    localparam logic [6:0] A_RM  = 7'd9;
    localparam logic [6:0] A_WD  = 7'd18;
    localparam logic [6:0] A_WM  = 7'd21;
    localparam logic [6:0] A_T   = 7'd24;
    localparam logic [6:0] A_TX  = 7'd25;
    localparam logic [6:0] A_TY  = 7'd26;
    localparam logic [6:0] A_TZ  = 7'd27;
    localparam logic [6:0] A_P   = 7'd28;
    localparam logic [6:0] A_Q   = 7'd29;
    localparam logic [6:0] A_R21 = 7'd30;
    localparam logic [6:0] A_R12 = 7'd31;
    localparam logic [6:0] A_R02 = 7'd32;
    localparam logic [6:0] A_R20 = 7'd33;
    localparam logic [6:0] A_R10 = 7'd34;
    localparam logic [6:0] A_R01 = 7'd35;
    localparam logic [6:0] A_ER  = 7'd36;
    localparam logic [6:0] A_V   = 7'd39;
    localparam logic [6:0] A_EW  = 7'd42;
    localparam logic [6:0] A_IW  = 7'd45;
    localparam logic [6:0] A_H   = 7'd48;
    localparam logic [6:0] A_M   = 7'd51;
    localparam int         MEM_DEPTH = 64;

    // operand codes outside the memory
    localparam logic [6:0] SP_ZERO  = 7'd64;
    localparam logic [6:0] SP_ONE   = 7'd65;
    localparam logic [6:0] SP_HALF  = 7'd66;
    localparam logic [6:0] SP_X     = 7'd67;
    localparam logic [6:0] SP_Y     = 7'd68;
    localparam logic [6:0] SP_Z     = 7'd69;
    localparam logic [6:0] SP_SIN   = 7'd70;
    localparam logic [6:0] SP_COS   = 7'd71;
    localparam logic [6:0] SP_KR_XY = 7'd72;
    localparam logic [6:0] SP_KR_Z  = 7'd73;
    localparam logic [6:0] SP_KW_XY = 7'd74;
    localparam logic [6:0] SP_KW_Z  = 7'd75;
    localparam logic [6:0] SP_I_XY  = 7'd76;
    localparam logic [6:0] SP_I_Z   = 7'd77;

    localparam logic [PC_W-1:0] PC_ROD  = 7'd0;
    localparam logic [PC_W-1:0] PC_RATE = 7'd22;
    localparam logic [PC_W-1:0] PC_TICK = 7'd25;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_FOLD, ST_CORD, ST_SC, ST_ISSUE, ST_EXEC, ST_WB, ST_HOLD
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD, OP_SUB, OP_MUL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] dst;
        logic       alt;
        logic [6:0] a;
        logic [6:0] b;
        logic [2:0] res;
        logic       last;
    } t_uop;

    function automatic logic [33:0] atan_q30(input logic [4:0] i);
        logic [33:0] v;
        unique case (i)
            5'd0:  v = 34'h03243F6A8;
            5'd1:  v = 34'h01DAC6705;
            5'd2:  v = 34'h00FADBAFC;
            5'd3:  v = 34'h007F56EA6;
            5'd4:  v = 34'h003FEAB76;
            5'd5:  v = 34'h001FFD55B;
            5'd6:  v = 34'h000FFFAAA;
            5'd7:  v = 34'h0007FFF55;
            5'd8:  v = 34'h0003FFFEA;
            5'd9:  v = 34'h0001FFFFD;
            5'd10: v = 34'h0000FFFFF;
            5'd11: v = 34'h00007FFFF;
            5'd12: v = 34'h00003FFFF;
            5'd13: v = 34'h00001FFFF;
            5'd14: v = 34'h00000FFFF;
            5'd15: v = 34'h000007FFF;
            5'd16: v = 34'h000003FFF;
            5'd17: v = 34'h000001FFF;
            5'd18: v = 34'h000000FFF;
            5'd19: v = 34'h0000007FF;
            5'd20: v = 34'h0000003FF;
            5'd21: v = 34'h0000001FF;
            5'd22: v = 34'h0000000FF;
            5'd23: v = 34'h00000007F;
            5'd24: v = 34'h00000003F;
            5'd25: v = 34'h00000001F;
            5'd26: v = 34'h00000000F;
            5'd27: v = 34'h000000008;
            5'd28: v = 34'h000000004;
            5'd29: v = 34'h000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_uop mk(input t_op op, input logic [6:0] dst, input logic alt,
                                input logic [6:0] a, input logic [6:0] b,
                                input logic [2:0] res, input logic last);
        t_uop u;
        u.op   = op;
        u.dst  = dst[5:0];
        u.alt  = alt;
        u.a    = a;
        u.b    = b;
        u.res  = res;
        u.last = last;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // rodrigues, rotation destinations offset per command
            7'd0:  u = mk(OP_SUB, A_T,  0, SP_ONE, SP_COS, RES_NONE, 0);
            7'd1:  u = mk(OP_MUL, A_TX, 0, A_T, SP_X, RES_NONE, 0);
            7'd2:  u = mk(OP_MUL, A_TY, 0, A_T, SP_Y, RES_NONE, 0);
            7'd3:  u = mk(OP_MUL, A_TZ, 0, A_T, SP_Z, RES_NONE, 0);
            7'd4:  u = mk(OP_MUL, A_P,  0, A_TX, SP_X, RES_NONE, 0);
            7'd5:  u = mk(OP_ADD, A_RD + 7'd0, 1, SP_COS, A_P, RES_NONE, 0);
            7'd6:  u = mk(OP_MUL, A_P,  0, A_TX, SP_Y, RES_NONE, 0);
            7'd7:  u = mk(OP_MUL, A_Q,  0, SP_SIN, SP_Z, RES_NONE, 0);
            7'd8:  u = mk(OP_SUB, A_RD + 7'd1, 1, A_P, A_Q, RES_NONE, 0);
            7'd9:  u = mk(OP_ADD, A_RD + 7'd3, 1, A_P, A_Q, RES_NONE, 0);
            7'd10: u = mk(OP_MUL, A_P,  0, A_TX, SP_Z, RES_NONE, 0);
            7'd11: u = mk(OP_MUL, A_Q,  0, SP_SIN, SP_Y, RES_NONE, 0);
            7'd12: u = mk(OP_ADD, A_RD + 7'd2, 1, A_P, A_Q, RES_NONE, 0);
            7'd13: u = mk(OP_SUB, A_RD + 7'd6, 1, A_P, A_Q, RES_NONE, 0);
            7'd14: u = mk(OP_MUL, A_P,  0, A_TY, SP_Y, RES_NONE, 0);
            7'd15: u = mk(OP_ADD, A_RD + 7'd4, 1, SP_COS, A_P, RES_NONE, 0);
            7'd16: u = mk(OP_MUL, A_P,  0, A_TY, SP_Z, RES_NONE, 0);
            7'd17: u = mk(OP_MUL, A_Q,  0, SP_SIN, SP_X, RES_NONE, 0);
            7'd18: u = mk(OP_SUB, A_RD + 7'd5, 1, A_P, A_Q, RES_NONE, 0);
            7'd19: u = mk(OP_ADD, A_RD + 7'd7, 1, A_P, A_Q, RES_NONE, 0);
            7'd20: u = mk(OP_MUL, A_P,  0, A_TZ, SP_Z, RES_NONE, 0);
            7'd21: u = mk(OP_ADD, A_RD + 7'd8, 1, SP_COS, A_P, RES_NONE, 1);
            // rate load
            7'd22: u = mk(OP_ADD, A_WD + 7'd0, 1, SP_X, SP_ZERO, RES_NONE, 0);
            7'd23: u = mk(OP_ADD, A_WD + 7'd1, 1, SP_Y, SP_ZERO, RES_NONE, 0);
            7'd24: u = mk(OP_ADD, A_WD + 7'd2, 1, SP_Z, SP_ZERO, RES_NONE, 1);
            // rd' * rm entries
            7'd25: u = mk(OP_MUL, A_R21, 0, A_RD + 7'd2, A_RM + 7'd1, RES_NONE, 0);
            7'd26: u = mk(OP_MUL, A_P,   0, A_RD + 7'd5, A_RM + 7'd4, RES_NONE, 0);
            7'd27: u = mk(OP_ADD, A_R21, 0, A_R21, A_P, RES_NONE, 0);
            7'd28: u = mk(OP_MUL, A_P,   0, A_RD + 7'd8, A_RM + 7'd7, RES_NONE, 0);
            7'd29: u = mk(OP_ADD, A_R21, 0, A_R21, A_P, RES_NONE, 0);
            7'd30: u = mk(OP_MUL, A_R12, 0, A_RD + 7'd1, A_RM + 7'd2, RES_NONE, 0);
            7'd31: u = mk(OP_MUL, A_P,   0, A_RD + 7'd4, A_RM + 7'd5, RES_NONE, 0);
            7'd32: u = mk(OP_ADD, A_R12, 0, A_R12, A_P, RES_NONE, 0);
            7'd33: u = mk(OP_MUL, A_P,   0, A_RD + 7'd7, A_RM + 7'd8, RES_NONE, 0);
            7'd34: u = mk(OP_ADD, A_R12, 0, A_R12, A_P, RES_NONE, 0);
            7'd35: u = mk(OP_MUL, A_R02, 0, A_RD + 7'd0, A_RM + 7'd2, RES_NONE, 0);
            7'd36: u = mk(OP_MUL, A_P,   0, A_RD + 7'd3, A_RM + 7'd5, RES_NONE, 0);
            7'd37: u = mk(OP_ADD, A_R02, 0, A_R02, A_P, RES_NONE, 0);
            7'd38: u = mk(OP_MUL, A_P,   0, A_RD + 7'd6, A_RM + 7'd8, RES_NONE, 0);
            7'd39: u = mk(OP_ADD, A_R02, 0, A_R02, A_P, RES_NONE, 0);
            7'd40: u = mk(OP_MUL, A_R20, 0, A_RD + 7'd2, A_RM + 7'd0, RES_NONE, 0);
            7'd41: u = mk(OP_MUL, A_P,   0, A_RD + 7'd5, A_RM + 7'd3, RES_NONE, 0);
            7'd42: u = mk(OP_ADD, A_R20, 0, A_R20, A_P, RES_NONE, 0);
            7'd43: u = mk(OP_MUL, A_P,   0, A_RD + 7'd8, A_RM + 7'd6, RES_NONE, 0);
            7'd44: u = mk(OP_ADD, A_R20, 0, A_R20, A_P, RES_NONE, 0);
            7'd45: u = mk(OP_MUL, A_R10, 0, A_RD + 7'd1, A_RM + 7'd0, RES_NONE, 0);
            7'd46: u = mk(OP_MUL, A_P,   0, A_RD + 7'd4, A_RM + 7'd3, RES_NONE, 0);
            7'd47: u = mk(OP_ADD, A_R10, 0, A_R10, A_P, RES_NONE, 0);
            7'd48: u = mk(OP_MUL, A_P,   0, A_RD + 7'd7, A_RM + 7'd6, RES_NONE, 0);
            7'd49: u = mk(OP_ADD, A_R10, 0, A_R10, A_P, RES_NONE, 0);
            7'd50: u = mk(OP_MUL, A_R01, 0, A_RD + 7'd0, A_RM + 7'd1, RES_NONE, 0);
            7'd51: u = mk(OP_MUL, A_P,   0, A_RD + 7'd3, A_RM + 7'd4, RES_NONE, 0);
            7'd52: u = mk(OP_ADD, A_R01, 0, A_R01, A_P, RES_NONE, 0);
            7'd53: u = mk(OP_MUL, A_P,   0, A_RD + 7'd6, A_RM + 7'd7, RES_NONE, 0);
            7'd54: u = mk(OP_ADD, A_R01, 0, A_R01, A_P, RES_NONE, 0);
            // attitude error
            7'd55: u = mk(OP_SUB, A_P, 0, A_R21, A_R12, RES_NONE, 0);
            7'd56: u = mk(OP_MUL, A_ER + 7'd0, 0, SP_HALF, A_P, RES_EX, 0);
            7'd57: u = mk(OP_SUB, A_P, 0, A_R02, A_R20, RES_NONE, 0);
            7'd58: u = mk(OP_MUL, A_ER + 7'd1, 0, SP_HALF, A_P, RES_EY, 0);
            7'd59: u = mk(OP_SUB, A_P, 0, A_R10, A_R01, RES_NONE, 0);
            7'd60: u = mk(OP_MUL, A_ER + 7'd2, 0, SP_HALF, A_P, RES_EZ, 0);
            // v = rd * wd
            7'd61: u = mk(OP_MUL, A_V + 7'd0, 0, A_RD + 7'd0, A_WD + 7'd0, RES_NONE, 0);
            7'd62: u = mk(OP_MUL, A_P, 0, A_RD + 7'd1, A_WD + 7'd1, RES_NONE, 0);
            7'd63: u = mk(OP_ADD, A_V + 7'd0, 0, A_V + 7'd0, A_P, RES_NONE, 0);
            7'd64: u = mk(OP_MUL, A_P, 0, A_RD + 7'd2, A_WD + 7'd2, RES_NONE, 0);
            7'd65: u = mk(OP_ADD, A_V + 7'd0, 0, A_V + 7'd0, A_P, RES_NONE, 0);
            7'd66: u = mk(OP_MUL, A_V + 7'd1, 0, A_RD + 7'd3, A_WD + 7'd0, RES_NONE, 0);
            7'd67: u = mk(OP_MUL, A_P, 0, A_RD + 7'd4, A_WD + 7'd1, RES_NONE, 0);
            7'd68: u = mk(OP_ADD, A_V + 7'd1, 0, A_V + 7'd1, A_P, RES_NONE, 0);
            7'd69: u = mk(OP_MUL, A_P, 0, A_RD + 7'd5, A_WD + 7'd2, RES_NONE, 0);
            7'd70: u = mk(OP_ADD, A_V + 7'd1, 0, A_V + 7'd1, A_P, RES_NONE, 0);
            7'd71: u = mk(OP_MUL, A_V + 7'd2, 0, A_RD + 7'd6, A_WD + 7'd0, RES_NONE, 0);
            7'd72: u = mk(OP_MUL, A_P, 0, A_RD + 7'd7, A_WD + 7'd1, RES_NONE, 0);
            7'd73: u = mk(OP_ADD, A_V + 7'd2, 0, A_V + 7'd2, A_P, RES_NONE, 0);
            7'd74: u = mk(OP_MUL, A_P, 0, A_RD + 7'd8, A_WD + 7'd2, RES_NONE, 0);
            7'd75: u = mk(OP_ADD, A_V + 7'd2, 0, A_V + 7'd2, A_P, RES_NONE, 0);
            // rate error ew = wm - rm' * v
            7'd76: u = mk(OP_MUL, A_Q, 0, A_RM + 7'd0, A_V + 7'd0, RES_NONE, 0);
            7'd77: u = mk(OP_MUL, A_P, 0, A_RM + 7'd3, A_V + 7'd1, RES_NONE, 0);
            7'd78: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd79: u = mk(OP_MUL, A_P, 0, A_RM + 7'd6, A_V + 7'd2, RES_NONE, 0);
            7'd80: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd81: u = mk(OP_SUB, A_EW + 7'd0, 0, A_WM + 7'd0, A_Q, RES_NONE, 0);
            7'd82: u = mk(OP_MUL, A_Q, 0, A_RM + 7'd1, A_V + 7'd0, RES_NONE, 0);
            7'd83: u = mk(OP_MUL, A_P, 0, A_RM + 7'd4, A_V + 7'd1, RES_NONE, 0);
            7'd84: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd85: u = mk(OP_MUL, A_P, 0, A_RM + 7'd7, A_V + 7'd2, RES_NONE, 0);
            7'd86: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd87: u = mk(OP_SUB, A_EW + 7'd1, 0, A_WM + 7'd1, A_Q, RES_NONE, 0);
            7'd88: u = mk(OP_MUL, A_Q, 0, A_RM + 7'd2, A_V + 7'd0, RES_NONE, 0);
            7'd89: u = mk(OP_MUL, A_P, 0, A_RM + 7'd5, A_V + 7'd1, RES_NONE, 0);
            7'd90: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd91: u = mk(OP_MUL, A_P, 0, A_RM + 7'd8, A_V + 7'd2, RES_NONE, 0);
            7'd92: u = mk(OP_ADD, A_Q, 0, A_Q, A_P, RES_NONE, 0);
            7'd93: u = mk(OP_SUB, A_EW + 7'd2, 0, A_WM + 7'd2, A_Q, RES_NONE, 0);
            // gyroscopic term
            7'd94: u = mk(OP_MUL, A_IW + 7'd0, 0, SP_I_XY, A_WM + 7'd0, RES_NONE, 0);
            7'd95: u = mk(OP_MUL, A_IW + 7'd1, 0, SP_I_XY, A_WM + 7'd1, RES_NONE, 0);
            7'd96: u = mk(OP_MUL, A_IW + 7'd2, 0, SP_I_Z,  A_WM + 7'd2, RES_NONE, 0);
            7'd97: u = mk(OP_MUL, A_P, 0, A_WM + 7'd1, A_IW + 7'd2, RES_NONE, 0);
            7'd98: u = mk(OP_MUL, A_Q, 0, A_WM + 7'd2, A_IW + 7'd1, RES_NONE, 0);
            7'd99: u = mk(OP_SUB, A_H + 7'd0, 0, A_P, A_Q, RES_NONE, 0);
            7'd100: u = mk(OP_MUL, A_P, 0, A_WM + 7'd2, A_IW + 7'd0, RES_NONE, 0);
            7'd101: u = mk(OP_MUL, A_Q, 0, A_WM + 7'd0, A_IW + 7'd2, RES_NONE, 0);
            7'd102: u = mk(OP_SUB, A_H + 7'd1, 0, A_P, A_Q, RES_NONE, 0);
            7'd103: u = mk(OP_MUL, A_P, 0, A_WM + 7'd0, A_IW + 7'd1, RES_NONE, 0);
            7'd104: u = mk(OP_MUL, A_Q, 0, A_WM + 7'd1, A_IW + 7'd0, RES_NONE, 0);
            7'd105: u = mk(OP_SUB, A_H + 7'd2, 0, A_P, A_Q, RES_NONE, 0);
            // moment
            7'd106: u = mk(OP_MUL, A_P, 0, SP_KR_XY, A_ER + 7'd0, RES_NONE, 0);
            7'd107: u = mk(OP_MUL, A_Q, 0, SP_KW_XY, A_EW + 7'd0, RES_NONE, 0);
            7'd108: u = mk(OP_ADD, A_P, 0, A_P, A_Q, RES_NONE, 0);
            7'd109: u = mk(OP_MUL, A_P, 0, SP_I_XY, A_P, RES_NONE, 0);
            7'd110: u = mk(OP_SUB, A_M, 0, A_H + 7'd0, A_P, RES_MX, 0);
            7'd111: u = mk(OP_MUL, A_P, 0, SP_KR_XY, A_ER + 7'd1, RES_NONE, 0);
            7'd112: u = mk(OP_MUL, A_Q, 0, SP_KW_XY, A_EW + 7'd1, RES_NONE, 0);
            7'd113: u = mk(OP_ADD, A_P, 0, A_P, A_Q, RES_NONE, 0);
            7'd114: u = mk(OP_MUL, A_P, 0, SP_I_XY, A_P, RES_NONE, 0);
            7'd115: u = mk(OP_SUB, A_M, 0, A_H + 7'd1, A_P, RES_MY, 0);
            7'd116: u = mk(OP_MUL, A_P, 0, SP_KR_Z, A_ER + 7'd2, RES_NONE, 0);
            7'd117: u = mk(OP_MUL, A_Q, 0, SP_KW_Z, A_EW + 7'd2, RES_NONE, 0);
            7'd118: u = mk(OP_ADD, A_P, 0, A_P, A_Q, RES_NONE, 0);
            7'd119: u = mk(OP_MUL, A_P, 0, SP_I_Z, A_P, RES_NONE, 0);
            7'd120: u = mk(OP_SUB, A_M, 0, A_H + 7'd2, A_P, RES_MZ, 1);
            default: u = mk(OP_ADD, A_M, 0, SP_ZERO, SP_ZERO, RES_NONE, 1);
        endcase
        return u;
    endfunction

endpackage

FILE: src/so3_attitude_moment_controller.sv
// so3 attitude moment controller: microcoded read-modify-write datapath over one state memory
// depends on so3amc_pkg
// sequence: rate words run the microcode only; attitude words run angle reduction, then cordic,
//   then the microcode; a tick runs the microcode and then the output handoff
// throughput: one word at a time, set by the single shared multiply/add unit
// reset: rotations and rates read as zero, gains and inertia take their default values
module so3_attitude_moment_controller
    import so3amc_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value_angle,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_moment_x,
    output logic signed [31:0] o_moment_y,
    output logic signed [31:0] o_moment_z,
    output logic signed [31:0] o_att_error_x,
    output logic signed [31:0] o_att_error_y,
    output logic signed [31:0] o_att_error_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W    = WORD_WIDTH;
    localparam int SATW = 2 * W + 2;
    localparam int QW   = W + 31 - FRAC_BITS;
    localparam int RW   = QW + 34;
    localparam int KW   = $clog2(QW);
    localparam int MAW  = $clog2(MEM_DEPTH);

    localparam logic signed [SATW-1:0] SMAX  = (SATW'(1) <<< (W - 1)) - SATW'(1);
    localparam logic signed [SATW-1:0] SMIN  = -SMAX - SATW'(1);
    localparam logic signed [SATW-1:0] O_MAX = SATW'(signed'(33'h0_7FFF_FFFF));
    localparam logic signed [SATW-1:0] O_MIN = SATW'(signed'(33'h1_8000_0000));

    localparam logic [63:0] RV_KR_XY = 64'd5 << FRAC_BITS;
    localparam logic [63:0] RV_KR_Z  = 64'd3 << FRAC_BITS;
    localparam logic [63:0] RV_KW_XY = 64'd3 << FRAC_BITS;
    localparam logic [63:0] RV_KW_Z  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] RV_I_XY  = ((64'd24 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] RV_I_Z   = ((64'd48 << FRAC_BITS) + 64'd5) / 64'd10;

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] r;
        if (v > SMAX) begin
            r = SMAX;
        end else if (v < SMIN) begin
            r = SMIN;
        end else begin
            r = v;
        end
        return r[W-1:0];
    endfunction

    function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
        logic signed [SATW-1:0] e;
        e = SATW'(v);
        if (e > O_MAX) begin
            e = O_MAX;
        end else if (e < O_MIN) begin
            e = O_MIN;
        end
        return e[31:0];
    endfunction

    localparam logic signed [W-1:0] ONE_VAL  = sat_w(SATW'(1) <<< FRAC_BITS);
    localparam logic signed [W-1:0] HALF_VAL = sat_w(SATW'(1) <<< (FRAC_BITS - 1));

    t_state r_state, n_state;

    logic [31:0]           r_cfg [CFG_NUM];
    logic signed [W-1:0]   r_in_ang, r_in_x, r_in_y, r_in_z;
    logic [5:0]            r_off;
    logic                  r_tick;
    logic [PC_W-1:0]       r_pc;
    logic [RW-1:0]         r_m;
    logic                  r_neg;
    logic [KW-1:0]         r_k;
    logic signed [33:0]    r_cx, r_cy, r_cr;
    logic                  r_flip;
    logic [4:0]            r_ci;
    logic signed [W-1:0]   r_sin, r_cos;
    logic [W-1:0]          r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_vld;
    logic [W-1:0]          r_rda, r_rdb;
    logic                  r_va, r_vb;
    logic [2*W-1:0]        r_prod;
    logic                  r_pneg;
    logic signed [SATW-1:0] r_sum;
    logic signed [W-1:0]   r_res [6];
    logic                  r_ovalid;

    t_uop                  cur;
    logic                  in_acc;
    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic [MAW-1:0]        wr_addr;
    logic signed [W-1:0]   a_val, b_val, wb_val;
    logic [W-1:0]          a_mag, b_mag;
    logic [2*W-1:0]        q;
    logic signed [SATW-1:0] mq, mv;
    logic [RW-1:0]         t_ang, c_sh;
    logic signed [33:0]    f0, f1, f2, y_sh, x_sh, x_fin;
    logic                  f_flip;
    logic [33:0]           m_lo;

    assign cur     = uop_rom(r_pc);
    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && (32'(cfg_idx) < CFG_NUM);
    assign prdata  = (32'(cfg_idx) < CFG_NUM) ? r_cfg[cfg_idx] : '0;
    assign o_valid = r_ovalid;
    assign wr_addr = cur.dst + (cur.alt ? r_off : 6'd0);

    function automatic logic signed [W-1:0] cfg_w(input logic [31:0] v);
        return sat_w(SATW'(signed'({1'b0, v})));
    endfunction

    function automatic logic signed [W-1:0] operand(input logic [6:0] code,
                                                   input logic [W-1:0] md, input logic mv_);
        logic signed [W-1:0] r;
        if (!code[6]) begin
            r = mv_ ? md : '0;
        end else begin
            case (code)
                SP_ONE:   r = ONE_VAL;
                SP_HALF:  r = HALF_VAL;
                SP_X:     r = r_in_x;
                SP_Y:     r = r_in_y;
                SP_Z:     r = r_in_z;
                SP_SIN:   r = r_sin;
                SP_COS:   r = r_cos;
                SP_KR_XY: r = cfg_w(r_cfg[CFG_KR_XY]);
                SP_KR_Z:  r = cfg_w(r_cfg[CFG_KR_Z]);
                SP_KW_XY: r = cfg_w(r_cfg[CFG_KW_XY]);
                SP_KW_Z:  r = cfg_w(r_cfg[CFG_KW_Z]);
                SP_I_XY:  r = cfg_w(r_cfg[CFG_I_XY]);
                SP_I_Z:   r = cfg_w(r_cfg[CFG_I_Z]);
                default:  r = '0;
            endcase
        end
        return r;
    endfunction

    always_comb begin
        a_val = operand(cur.a, r_rda, r_va);
        b_val = operand(cur.b, r_rdb, r_vb);
        a_mag = a_val[W-1] ? W'(-a_val) : W'(a_val);
        b_mag = b_val[W-1] ? W'(-b_val) : W'(b_val);
        q     = r_prod >> FRAC_BITS;
        mq    = SATW'(q) + SATW'(r_pneg && (r_prod[FRAC_BITS-1:0] != '0));
        mv    = r_pneg ? -mq : mq;
        wb_val = sat_w((cur.op == OP_MUL) ? mv : r_sum);
    end

    // angle reduction and cordic helpers
    always_comb begin
        t_ang = RW'(r_in_ang) << (30 - FRAC_BITS);
        if (r_in_ang[W-1]) begin
            t_ang = -t_ang;
        end
        c_sh  = RW'(Q30_TWO_PI) << r_k;
        m_lo  = r_m[33:0];
        f0    = (r_neg && (m_lo != '0)) ? signed'(Q30_TWO_PI - m_lo) : signed'(m_lo);
        f1    = (f0 > signed'(Q30_PI)) ? f0 - signed'(Q30_TWO_PI) : f0;
        f_flip = 1'b0;
        f2    = f1;
        if (f1 > signed'(Q30_HALF_PI)) begin
            f2 = signed'(Q30_PI) - f1;
            f_flip = 1'b1;
        end else if (f1 < -signed'(Q30_HALF_PI)) begin
            f2 = -signed'(Q30_PI) - f1;
            f_flip = 1'b1;
        end
        y_sh  = r_cy >>> r_ci;
        x_sh  = r_cx >>> r_ci;
        x_fin = r_flip ? -r_cx : r_cx;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_command == CMD_SET_RD || i_command == CMD_SET_RM) begin
                        n_state = ST_RED;
                    end else if (i_command == CMD_SET_WD || i_command == CMD_SET_WM
                                 || i_command == CMD_TICK) begin
                        n_state = ST_ISSUE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RED:   if (r_k == '0) n_state = ST_FOLD;
            ST_FOLD:  n_state = ST_CORD;
            ST_CORD:  if (r_ci == 5'(CORDIC_STEPS - 1)) n_state = ST_SC;
            ST_SC:    n_state = ST_ISSUE;
            ST_ISSUE: n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_WB;
            ST_WB: begin
                if (cur.last) begin
                    n_state = r_tick ? ST_HOLD : ST_IDLE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_HOLD:  if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_KR_XY] <= clamp32(RV_KR_XY);
            r_cfg[CFG_KR_Z]  <= clamp32(RV_KR_Z);
            r_cfg[CFG_KW_XY] <= clamp32(RV_KW_XY);
            r_cfg[CFG_KW_Z]  <= clamp32(RV_KW_Z);
            r_cfg[CFG_I_XY]  <= clamp32(RV_I_XY);
            r_cfg[CFG_I_Z]   <= clamp32(RV_I_Z);
        end else if (cfg_wr) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    // state memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            r_mem[wr_addr] <= wb_val;
        end
        r_rda <= r_mem[cur.a[MAW-1:0]];
        r_rdb <= r_mem[cur.b[MAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (r_state == ST_WB) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_va <= r_vld[cur.a[MAW-1:0]];
            r_vb <= r_vld[cur.b[MAW-1:0]];
        end
    end

    // control and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_off    <= '0;
            r_tick   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_tick <= (i_command == CMD_TICK);
                        priority if (i_command == CMD_SET_RD || i_command == CMD_SET_RM) begin
                            r_pc  <= PC_ROD;
                            r_off <= (i_command == CMD_SET_RM) ? A_RM[5:0] : 6'd0;
                        end else if (i_command == CMD_SET_WD || i_command == CMD_SET_WM) begin
                            r_pc  <= PC_RATE;
                            r_off <= (i_command == CMD_SET_WM) ? 6'(A_WM - A_WD) : 6'd0;
                        end else begin
                            r_pc  <= PC_TICK;
                            r_off <= 6'd0;
                        end
                    end
                end
                ST_WB: begin
                    if (!cur.last) begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_in_ang <= sat_w(SATW'(i_value_angle));
                    r_in_x   <= sat_w(SATW'(i_value_x));
                    r_in_y   <= sat_w(SATW'(i_value_y));
                    r_in_z   <= sat_w(SATW'(i_value_z));
                end
                r_k <= KW'(QW - 1);
            end
            ST_RED: begin
                if (r_k == KW'(QW - 1)) begin
                    r_neg <= r_in_ang[W-1];
                    r_m   <= (t_ang >= c_sh) ? t_ang - c_sh : t_ang;
                end else if (r_m >= c_sh) begin
                    r_m <= r_m - c_sh;
                end
                if (r_k != '0) begin
                    r_k <= r_k - 1'b1;
                end
            end
            ST_FOLD: begin
                r_cr   <= f2;
                r_flip <= f_flip;
                r_cx   <= signed'(CORDIC_GAIN);
                r_cy   <= '0;
                r_ci   <= '0;
            end
            ST_CORD: begin
                if (!r_cr[33]) begin
                    r_cx <= r_cx - y_sh;
                    r_cy <= r_cy + x_sh;
                    r_cr <= r_cr - signed'(atan_q30(r_ci));
                end else begin
                    r_cx <= r_cx + y_sh;
                    r_cy <= r_cy - x_sh;
                    r_cr <= r_cr + signed'(atan_q30(r_ci));
                end
                r_ci <= r_ci + 1'b1;
            end
            ST_SC: begin
                r_sin <= sat_w(SATW'(r_cy >>> (30 - FRAC_BITS)));
                r_cos <= sat_w(SATW'(x_fin >>> (30 - FRAC_BITS)));
            end
            ST_EXEC: begin
                r_prod <= a_mag * b_mag;
                r_pneg <= a_val[W-1] ^ b_val[W-1];
                r_sum  <= (cur.op == OP_SUB) ? SATW'(a_val) - SATW'(b_val)
                                             : SATW'(a_val) + SATW'(b_val);
            end
            ST_WB: begin
                if (cur.res != RES_NONE) begin
                    r_res[cur.res - 3'd1] <= wb_val;
                end
            end
            ST_HOLD: begin
                if (!r_ovalid || !i_stall) begin
                    o_moment_x    <= out32(r_res[RES_MX - 3'd1]);
                    o_moment_y    <= out32(r_res[RES_MY - 3'd1]);
                    o_moment_z    <= out32(r_res[RES_MZ - 3'd1]);
                    o_att_error_x <= out32(r_res[RES_EX - 3'd1]);
                    o_att_error_y <= out32(r_res[RES_EY - 3'd1]);
                    o_att_error_z <= out32(r_res[RES_EZ - 3'd1]);
                end
            end
            default: begin
            end
        endcase
    end

endmodule
